[src/asgr_pkg.sv]
// Types, codes and SGR update functions for the ANSI SGR attribute parser.
package asgr_pkg;

	localparam int unsigned ParamW  = 10;
	localparam int unsigned StyleW  = 10;
	localparam int unsigned ColourW = 9;
	localparam int unsigned OutW    = 40;

	localparam logic [ParamW-1:0] ParamMax = 10'd1023;
	localparam logic [ParamW-1:0] IdxMax   = 10'd255;

	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_DIGIT9 = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_FINLO  = 8'h40;
	localparam logic [7:0] CH_FINHI  = 8'h7E;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_SGR    = 8'h6D;

	localparam logic [ParamW-1:0] SGR_RESET     = 10'd0;
	localparam logic [ParamW-1:0] SGR_BOLD      = 10'd1;
	localparam logic [ParamW-1:0] SGR_DIM       = 10'd2;
	localparam logic [ParamW-1:0] SGR_ITALIC    = 10'd3;
	localparam logic [ParamW-1:0] SGR_ULINE     = 10'd4;
	localparam logic [ParamW-1:0] SGR_BLINK     = 10'd5;
	localparam logic [ParamW-1:0] SGR_INVERSE   = 10'd7;
	localparam logic [ParamW-1:0] SGR_HIDDEN    = 10'd8;
	localparam logic [ParamW-1:0] SGR_STRIKE    = 10'd9;
	localparam logic [ParamW-1:0] SGR_DULINE    = 10'd21;
	localparam logic [ParamW-1:0] SGR_NO_BOLD   = 10'd22;
	localparam logic [ParamW-1:0] SGR_NO_ITALIC = 10'd23;
	localparam logic [ParamW-1:0] SGR_NO_ULINE  = 10'd24;
	localparam logic [ParamW-1:0] SGR_NO_BLINK  = 10'd25;
	localparam logic [ParamW-1:0] SGR_NO_INV    = 10'd27;
	localparam logic [ParamW-1:0] SGR_NO_HIDDEN = 10'd28;
	localparam logic [ParamW-1:0] SGR_NO_STRIKE = 10'd29;
	localparam logic [ParamW-1:0] SGR_OLINE     = 10'd53;
	localparam logic [ParamW-1:0] SGR_NO_OLINE  = 10'd55;
	localparam logic [ParamW-1:0] SGR_FG_EXT    = 10'd38;
	localparam logic [ParamW-1:0] SGR_BG_EXT    = 10'd48;
	localparam logic [ParamW-1:0] SGR_FG_DEF    = 10'd39;
	localparam logic [ParamW-1:0] SGR_BG_DEF    = 10'd49;
	localparam logic [ParamW-1:0] SGR_EXT_256   = 10'd5;
	localparam logic [ParamW-1:0] SGR_FG_LO     = 10'd30;
	localparam logic [ParamW-1:0] SGR_FG_HI     = 10'd37;
	localparam logic [ParamW-1:0] SGR_FGB_LO    = 10'd90;
	localparam logic [ParamW-1:0] SGR_FGB_HI    = 10'd97;
	localparam logic [ParamW-1:0] SGR_BG_LO     = 10'd40;
	localparam logic [ParamW-1:0] SGR_BG_HI     = 10'd47;
	localparam logic [ParamW-1:0] SGR_BGB_LO    = 10'd100;
	localparam logic [ParamW-1:0] SGR_BGB_HI    = 10'd107;

	localparam logic [StyleW-1:0] ST_BOLD    = 10'h001;
	localparam logic [StyleW-1:0] ST_DIM     = 10'h002;
	localparam logic [StyleW-1:0] ST_ITALIC  = 10'h004;
	localparam logic [StyleW-1:0] ST_ULINE   = 10'h008;
	localparam logic [StyleW-1:0] ST_BLINK   = 10'h010;
	localparam logic [StyleW-1:0] ST_INVERSE = 10'h020;
	localparam logic [StyleW-1:0] ST_HIDDEN  = 10'h040;
	localparam logic [StyleW-1:0] ST_STRIKE  = 10'h080;
	localparam logic [StyleW-1:0] ST_DULINE  = 10'h100;
	localparam logic [StyleW-1:0] ST_OLINE   = 10'h200;

	// bit 8 set = default colour, bits 7..0 = palette index
	localparam logic [ColourW-1:0] COLOUR_DEFAULT = 9'h100;

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_CSI,
		MODE_OSC
	} mode_t;

	typedef enum logic [2:0] {
		EXT_NONE,
		EXT_FG,
		EXT_FG5,
		EXT_BG,
		EXT_BG5
	} ext_t;

	typedef struct packed {
		logic [StyleW-1:0]  style;
		logic [ColourW-1:0] fg;
		logic [ColourW-1:0] bg;
		ext_t               ext;
	} attr_t;

	function automatic attr_t apply_code(attr_t a, logic [ParamW-1:0] code);
		attr_t r;
		r = a;
		unique case (code)
			SGR_RESET: begin
				r.style = '0;
				r.fg    = COLOUR_DEFAULT;
				r.bg    = COLOUR_DEFAULT;
			end
			SGR_BOLD:      r.style = a.style | ST_BOLD;
			SGR_DIM:       r.style = a.style | ST_DIM;
			SGR_ITALIC:    r.style = a.style | ST_ITALIC;
			SGR_ULINE:     r.style = a.style | ST_ULINE;
			SGR_BLINK:     r.style = a.style | ST_BLINK;
			SGR_INVERSE:   r.style = a.style | ST_INVERSE;
			SGR_HIDDEN:    r.style = a.style | ST_HIDDEN;
			SGR_STRIKE:    r.style = a.style | ST_STRIKE;
			SGR_DULINE:    r.style = a.style | ST_DULINE;
			SGR_NO_BOLD:   r.style = a.style & ~(ST_BOLD | ST_DIM);
			SGR_NO_ITALIC: r.style = a.style & ~ST_ITALIC;
			SGR_NO_ULINE:  r.style = a.style & ~(ST_ULINE | ST_DULINE);
			SGR_NO_BLINK:  r.style = a.style & ~ST_BLINK;
			SGR_NO_INV:    r.style = a.style & ~ST_INVERSE;
			SGR_NO_HIDDEN: r.style = a.style & ~ST_HIDDEN;
			SGR_NO_STRIKE: r.style = a.style & ~ST_STRIKE;
			SGR_OLINE:     r.style = a.style | ST_OLINE;
			SGR_NO_OLINE:  r.style = a.style & ~ST_OLINE;
			SGR_FG_DEF:    r.fg = COLOUR_DEFAULT;
			SGR_BG_DEF:    r.bg = COLOUR_DEFAULT;
			SGR_FG_EXT:    r.ext = EXT_FG;
			SGR_BG_EXT:    r.ext = EXT_BG;
			default: begin
				if (code >= SGR_FG_LO && code <= SGR_FG_HI)
					r.fg = ColourW'(code - SGR_FG_LO);
				else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI)
					r.fg = ColourW'(code - SGR_FGB_LO + 10'd8);
				else if (code >= SGR_BG_LO && code <= SGR_BG_HI)
					r.bg = ColourW'(code - SGR_BG_LO);
				else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI)
					r.bg = ColourW'(code - SGR_BGB_LO + 10'd8);
			end
		endcase
		return r;
	endfunction

	function automatic attr_t end_param(attr_t a, logic [ParamW-1:0] val, logic qmark);
		attr_t              r;
		attr_t              c;
		logic [ParamW-1:0]  p;
		logic [ColourW-1:0] idx;
		p     = qmark ? '0 : val;
		idx   = (p > IdxMax) ? ColourW'(IdxMax) : ColourW'(p);
		c     = a;
		c.ext = EXT_NONE;
		unique case (a.ext)
			EXT_FG: begin
				if (p == SGR_EXT_256) begin
					r     = a;
					r.ext = EXT_FG5;
				end else begin
					r = apply_code(c, p);
				end
			end
			EXT_BG: begin
				if (p == SGR_EXT_256) begin
					r     = a;
					r.ext = EXT_BG5;
				end else begin
					r = apply_code(c, p);
				end
			end
			EXT_FG5: begin
				r    = c;
				r.fg = idx;
			end
			EXT_BG5: begin
				r    = c;
				r.bg = idx;
			end
			default: r = apply_code(c, p);
		endcase
		return r;
	endfunction

endpackage

[src/ansi_sgr_attribute_parser.sv]
// ANSI SGR attribute parser: byte stream in, printable bytes with attributes out.
// A byte is registered at its input transaction; its result is loaded into the output
// register when the byte advances, which waits while m_axis holds an untaken result.
// Throughput: one byte per cycle while m_axis does not hold an untaken result.
// Reset (arst_n low, asynchronous): text mode, all styles clear, both colours default,
// both stream sides empty.
module ansi_sgr_attribute_parser import asgr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,  // byte_in
	input  logic          s_axis_tlast,  // chunk_end
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [OutW-1:0] m_axis_tdata // char_code, fg_is_default, fg_index,
	                                     // bg_is_default, bg_index, style_flags, zero pad
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                chunk_s1;

	mode_t               mode_q, mode_d;
	logic [ParamW-1:0]   pval_q, pval_d;
	logic                qmark_q, qmark_d;
	attr_t               work_q, work_d;
	logic [StyleW-1:0]   cstyle_q, cstyle_d;
	logic [ColourW-1:0]  cfg_q, cfg_d;
	logic [ColourW-1:0]  cbg_q, cbg_d;

	logic                out_valid_q;
	logic [OutW-1:0]     out_data_q;

	logic                advance;
	logic                emit;
	logic                text_path;
	logic [ParamW+3:0]   pval_sum;
	attr_t               fin;
	logic [OutW-1:0]     out_word;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign pval_sum = {1'b0, pval_q, 3'b000} + {3'b000, pval_q, 1'b0}
		+ {6'd0, byte_s1 - CH_DIGIT0};

	always_comb begin
		mode_d    = mode_q;
		pval_d    = pval_q;
		qmark_d   = qmark_q;
		work_d    = work_q;
		cstyle_d  = cstyle_q;
		cfg_d     = cfg_q;
		cbg_d     = cbg_q;
		text_path = 1'b0;
		emit      = 1'b0;
		fin       = end_param(work_q, pval_q, qmark_q);
		if (fin.ext == EXT_FG5 || fin.ext == EXT_BG5)
			fin = apply_code(fin, SGR_EXT_256);
		unique case (mode_q)
			MODE_ESC: begin
				if (byte_s1 == CH_LBRK) begin
					mode_d  = MODE_CSI;
					pval_d  = '0;
					qmark_d = 1'b0;
					work_d  = '{style: cstyle_q, fg: cfg_q, bg: cbg_q, ext: EXT_NONE};
				end else if (byte_s1 == CH_RBRK) begin
					mode_d = MODE_OSC;
				end else begin
					text_path = 1'b1;
				end
			end
			MODE_CSI: begin
				if (byte_s1 >= CH_DIGIT0 && byte_s1 <= CH_DIGIT9) begin
					pval_d = (pval_sum > (ParamW+4)'(ParamMax)) ? ParamMax
						: pval_sum[ParamW-1:0];
				end else if (byte_s1 == CH_QMARK) begin
					qmark_d = 1'b1;
				end else if (byte_s1 == CH_SEMI) begin
					work_d  = end_param(work_q, pval_q, qmark_q);
					pval_d  = '0;
					qmark_d = 1'b0;
				end else if (byte_s1 >= CH_FINLO && byte_s1 <= CH_FINHI) begin
					if (byte_s1 == CH_SGR) begin
						work_d   = fin;
						pval_d   = '0;
						qmark_d  = 1'b0;
						cstyle_d = fin.style;
						cfg_d    = fin.fg;
						cbg_d    = fin.bg;
					end
					mode_d = MODE_TEXT;
				end else begin
					text_path = 1'b1;
				end
			end
			MODE_OSC: begin
				if (byte_s1 == CH_BEL)
					mode_d = MODE_TEXT;
			end
			default: text_path = 1'b1;
		endcase
		if (text_path) begin
			if (byte_s1 == CH_ESC) begin
				mode_d = MODE_ESC;
			end else begin
				mode_d = MODE_TEXT;
				emit   = (byte_s1 != CH_CR) && (byte_s1 != CH_BS);
			end
		end
		if (chunk_s1 && mode_d != MODE_TEXT) begin
			mode_d     = MODE_TEXT;
			pval_d     = '0;
			qmark_d    = 1'b0;
			work_d.ext = EXT_NONE;
		end
	end

	assign out_word = {4'd0, cstyle_q,
		cbg_q[8] ? 8'd0 : cbg_q[7:0], cbg_q[8],
		cfg_q[8] ? 8'd0 : cfg_q[7:0], cfg_q[8],
		byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			chunk_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TEXT;
			pval_q   <= '0;
			qmark_q  <= 1'b0;
			work_q   <= '{style: '0, fg: COLOUR_DEFAULT, bg: COLOUR_DEFAULT, ext: EXT_NONE};
			cstyle_q <= '0;
			cfg_q    <= COLOUR_DEFAULT;
			cbg_q    <= COLOUR_DEFAULT;
		end else if (advance) begin
			mode_q   <= mode_d;
			pval_q   <= pval_d;
			qmark_q  <= qmark_d;
			work_q   <= work_d;
			cstyle_q <= cstyle_d;
			cfg_q    <= cfg_d;
			cbg_q    <= cbg_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			out_data_q <= out_word;
	end

	a_chunk_to_text: assert property (@(posedge clk) disable iff (!arst_n)
		advance && chunk_s1 |=> mode_q == MODE_TEXT)
		else $error("chunk end left a sequence open");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> out_valid_q && out_data_q[7:0] == $past(byte_s1))
		else $error("result not loaded");

	a_default_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q[8] || out_data_q[16:9] == 8'd0)
			&& (!out_data_q[17] || out_data_q[25:18] == 8'd0))
		else $error("default colour with nonzero index");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(mode_q))
		else $error("stalled byte lost or state moved");

	a_no_emit_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (byte_s1 == CH_CR || byte_s1 == CH_BS || byte_s1 == CH_ESC) |-> !emit)
		else $error("control byte emitted");

endmodule

[tb/sv/tb_ansi_sgr_attribute_parser.sv]
// Testbench for ansi_sgr_attribute_parser: directed and random byte streams, checked by a predictor.
module tb_ansi_sgr_attribute_parser;
	import asgr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IdleLimit   = 2000;
	localparam int unsigned RandomBytes = 330;

	typedef struct {
		logic [7:0]        char_code;
		logic              fg_is_default;
		logic [7:0]        fg_index;
		logic              bg_is_default;
		logic [7:0]        bg_index;
		logic [StyleW-1:0] style_flags;
	} glyph_t;

	logic            clk;
	logic            arst_n        = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [7:0]      s_axis_tdata  = '0;
	logic            s_axis_tlast  = 1'b0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [OutW-1:0] m_axis_tdata;

	int unsigned send_idle_pct  = 23;
	int unsigned recv_stall_pct = 65;
	int unsigned bytes_sent     = 0;
	int unsigned errors         = 0;
	int unsigned idle_cycles    = 0;

	glyph_t pending_glyphs[$];

	// predictor state
	mode_t              p_mode;
	logic [ParamW-1:0]  p_param;
	logic               p_qmark;
	ext_t               p_ext;
	logic [StyleW-1:0]  cur_style, wrk_style;
	logic [ColourW-1:0] cur_fg, cur_bg, wrk_fg, wrk_bg;

	ansi_sgr_attribute_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void apply_sgr(logic [ParamW-1:0] code);
		case (code)
			SGR_RESET: begin
				wrk_style = '0;
				wrk_fg    = COLOUR_DEFAULT;
				wrk_bg    = COLOUR_DEFAULT;
			end
			SGR_BOLD:      wrk_style |= ST_BOLD;
			SGR_DIM:       wrk_style |= ST_DIM;
			SGR_ITALIC:    wrk_style |= ST_ITALIC;
			SGR_ULINE:     wrk_style |= ST_ULINE;
			SGR_BLINK:     wrk_style |= ST_BLINK;
			SGR_INVERSE:   wrk_style |= ST_INVERSE;
			SGR_HIDDEN:    wrk_style |= ST_HIDDEN;
			SGR_STRIKE:    wrk_style |= ST_STRIKE;
			SGR_DULINE:    wrk_style |= ST_DULINE;
			SGR_NO_BOLD:   wrk_style &= ~(ST_BOLD | ST_DIM);
			SGR_NO_ITALIC: wrk_style &= ~ST_ITALIC;
			SGR_NO_ULINE:  wrk_style &= ~(ST_ULINE | ST_DULINE);
			SGR_NO_BLINK:  wrk_style &= ~ST_BLINK;
			SGR_NO_INV:    wrk_style &= ~ST_INVERSE;
			SGR_NO_HIDDEN: wrk_style &= ~ST_HIDDEN;
			SGR_NO_STRIKE: wrk_style &= ~ST_STRIKE;
			SGR_OLINE:     wrk_style |= ST_OLINE;
			SGR_NO_OLINE:  wrk_style &= ~ST_OLINE;
			SGR_FG_DEF:    wrk_fg = COLOUR_DEFAULT;
			SGR_BG_DEF:    wrk_bg = COLOUR_DEFAULT;
			SGR_FG_EXT:    p_ext = EXT_FG;
			SGR_BG_EXT:    p_ext = EXT_BG;
			default: begin
				if (code >= SGR_FG_LO && code <= SGR_FG_HI)
					wrk_fg = {1'b0, 8'(code - SGR_FG_LO)};
				else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI)
					wrk_fg = {1'b0, 8'(code - SGR_FGB_LO + 8)};
				else if (code >= SGR_BG_LO && code <= SGR_BG_HI)
					wrk_bg = {1'b0, 8'(code - SGR_BG_LO)};
				else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI)
					wrk_bg = {1'b0, 8'(code - SGR_BGB_LO + 8)};
			end
		endcase
	endfunction

	function automatic void close_param();
		logic [ParamW-1:0]  code;
		logic [ColourW-1:0] pal;
		code    = p_qmark ? '0 : p_param;
		pal     = {1'b0, (code > 255) ? 8'hFF : code[7:0]};
		p_param = '0;
		p_qmark = 1'b0;
		case (p_ext)
			EXT_FG: begin
				if (code == SGR_EXT_256) begin
					p_ext = EXT_FG5;
				end else begin
					p_ext = EXT_NONE;
					apply_sgr(code);
				end
			end
			EXT_BG: begin
				if (code == SGR_EXT_256) begin
					p_ext = EXT_BG5;
				end else begin
					p_ext = EXT_NONE;
					apply_sgr(code);
				end
			end
			EXT_FG5: begin
				wrk_fg = pal;
				p_ext  = EXT_NONE;
			end
			EXT_BG5: begin
				wrk_bg = pal;
				p_ext  = EXT_NONE;
			end
			default: begin
				p_ext = EXT_NONE;
				apply_sgr(code);
			end
		endcase
	endfunction

	function automatic void emit_text(logic [7:0] b);
		glyph_t g;
		if (b == CH_ESC) begin
			p_mode = MODE_ESC;
		end else if (b != CH_CR && b != CH_BS) begin
			g.char_code     = b;
			g.fg_is_default = cur_fg[8];
			g.fg_index      = cur_fg[8] ? 8'h00 : cur_fg[7:0];
			g.bg_is_default = cur_bg[8];
			g.bg_index      = cur_bg[8] ? 8'h00 : cur_bg[7:0];
			g.style_flags   = cur_style;
			pending_glyphs.push_back(g);
		end
	endfunction

	function automatic void model_byte(logic [7:0] b, logic chunk_end);
		int unsigned acc;
		case (p_mode)
			MODE_ESC: begin
				if (b == CH_LBRK) begin
					p_mode    = MODE_CSI;
					p_param   = '0;
					p_qmark   = 1'b0;
					p_ext     = EXT_NONE;
					wrk_style = cur_style;
					wrk_fg    = cur_fg;
					wrk_bg    = cur_bg;
				end else if (b == CH_RBRK) begin
					p_mode = MODE_OSC;
				end else begin
					p_mode = MODE_TEXT;
					emit_text(b);
				end
			end
			MODE_CSI: begin
				if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
					acc     = p_param * 10 + (b - CH_DIGIT0);
					p_param = (acc > ParamMax) ? ParamMax : ParamW'(acc);
				end else if (b == CH_QMARK) begin
					p_qmark = 1'b1;
				end else if (b == CH_SEMI) begin
					close_param();
				end else if (b >= CH_FINLO && b <= CH_FINHI) begin
					if (b == CH_SGR) begin
						close_param();
						if (p_ext == EXT_FG5 || p_ext == EXT_BG5)
							apply_sgr(SGR_BLINK);
						cur_style = wrk_style;
						cur_fg    = wrk_fg;
						cur_bg    = wrk_bg;
					end
					p_mode = MODE_TEXT;
				end else begin
					p_mode = MODE_TEXT;
					emit_text(b);
				end
			end
			MODE_OSC: begin
				if (b == CH_BEL)
					p_mode = MODE_TEXT;
			end
			default: emit_text(b);
		endcase
		if (chunk_end && p_mode != MODE_TEXT) begin
			p_mode  = MODE_TEXT;
			p_param = '0;
			p_qmark = 1'b0;
			p_ext   = EXT_NONE;
		end
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic chunk_end);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= chunk_end;
		do @(posedge clk); while (!s_axis_tready);
		model_byte(b, chunk_end);
		bytes_sent++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	task automatic push_number(input int unsigned v, input logic chunk_end);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], (i == s.len() - 1) ? chunk_end : 1'b0);
	endtask

	task automatic test_plain_bytes();
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_BS, 1'b0);
		push_str("a");
	endtask

	task automatic test_sgr_extremes();
		// 256-colour index clipped, oversized value saturates
		push_byte(CH_ESC, 1'b0);
		push_str("[38;5;9999mA");
		// qmark param resets, dangling 48;5 turns on blink
		push_byte(CH_ESC, 1'b0);
		push_str("[?;48;5mB");
		push_byte(CH_ESC, 1'b0);
		push_str("[mC");
	endtask

	task automatic test_sequence_faults();
		push_byte(CH_ESC, 1'b0);
		push_str("]x");
		push_byte(CH_BEL, 1'b0);
		push_byte(CH_ESC, 1'b0);
		push_str("[1 ");
		push_byte(CH_ESC, 1'b0);
		push_str("Q");
		push_byte(CH_ESC, 1'b0);
		push_str("[1HD");
		push_byte(CH_ESC, 1'b0);
		push_str("[");
		push_byte(CH_DIGIT0 + 8'd1, 1'b1);
		push_byte(CH_SGR, 1'b0);
	endtask

	function automatic int unsigned pick_code();
		logic [ParamW-1:0] known[] = '{SGR_RESET, SGR_BOLD, SGR_DIM, SGR_ITALIC, SGR_ULINE,
			SGR_BLINK, SGR_INVERSE, SGR_HIDDEN, SGR_STRIKE, SGR_DULINE, SGR_NO_BOLD,
			SGR_NO_ITALIC, SGR_NO_ULINE, SGR_NO_BLINK, SGR_NO_INV, SGR_NO_HIDDEN,
			SGR_NO_STRIKE, SGR_OLINE, SGR_NO_OLINE, SGR_FG_DEF, SGR_BG_DEF};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return known[$urandom_range(0, known.size() - 1)];
			4: return $urandom_range(SGR_FG_LO, SGR_FG_HI);
			5: return $urandom_range(SGR_FGB_LO, SGR_FGB_HI);
			6: return $urandom_range(SGR_BG_LO, SGR_BG_HI);
			7: return $urandom_range(SGR_BGB_LO, SGR_BGB_HI);
			8: return $urandom_range(0, 300);
			default: return $urandom_range(0, 20000);
		endcase
	endfunction

	function automatic logic chunk_flag();
		return ($urandom_range(0, 24) == 0);
	endfunction

	task automatic push_sgr_sequence();
		int unsigned n;
		logic [7:0]  fin;
		n = $urandom_range(0, 5);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_LBRK, chunk_flag());
		for (int i = 0; i < n; i++) begin
			if (i != 0)
				push_byte(CH_SEMI, chunk_flag());
			case ($urandom_range(0, 9))
				0: ;
				1: begin
					push_byte(CH_QMARK, chunk_flag());
					if ($urandom_range(0, 1))
						push_number(pick_code(), 1'b0);
				end
				2, 3: begin
					push_number($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT, 1'b0);
					if ($urandom_range(0, 3) != 0) begin
						push_byte(CH_SEMI, chunk_flag());
						push_number(SGR_EXT_256, 1'b0);
					end
				end
				default: push_number(pick_code(), 1'b0);
			endcase
		end
		case ($urandom_range(0, 19))
			0, 1: fin = 8'($urandom_range(CH_FINLO, CH_FINHI));
			2: fin = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h2F)) :
				8'($urandom_range(8'h7F, 8'hFF));
			default: fin = CH_SGR;
		endcase
		push_byte(fin, chunk_flag());
	endtask

	task automatic test_random_stream();
		int unsigned target;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 23; recv_stall_pct = 65; end
				1: begin send_idle_pct = 65; recv_stall_pct = 23; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			target = bytes_sent + RandomBytes / 3;
			while (bytes_sent < target) begin
				case ($urandom_range(0, 19))
					0, 1: begin
						push_byte(CH_ESC, 1'b0);
						push_byte(CH_RBRK, chunk_flag());
						repeat ($urandom_range(0, 5))
							push_byte(8'($urandom_range(0, 255)), chunk_flag());
						push_byte(CH_BEL, chunk_flag());
					end
					2, 3: begin
						push_byte(CH_ESC, chunk_flag());
						push_byte(8'($urandom_range(0, 255)), chunk_flag());
					end
					4, 5, 6, 7: begin
						repeat ($urandom_range(1, 6))
							push_byte(8'($urandom_range(0, 255)), chunk_flag());
					end
					default: begin
						push_sgr_sequence();
						repeat ($urandom_range(1, 4))
							push_byte(8'($urandom_range(8'h20, 8'h7E)), chunk_flag());
					end
				endcase
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_glyphs.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %0h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_glyphs.pop_front();
				check_field("char_code", want.char_code, m_axis_tdata[7:0]);
				check_field("fg_is_default", want.fg_is_default, m_axis_tdata[8]);
				check_field("fg_index", want.fg_index, m_axis_tdata[16:9]);
				check_field("bg_is_default", want.bg_is_default, m_axis_tdata[17]);
				check_field("bg_index", want.bg_index, m_axis_tdata[25:18]);
				check_field("style_flags", want.style_flags, m_axis_tdata[35:26]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[ansi_sgr_attribute_parser] ERROR");
			$finish;
		end
	end

	initial begin
		p_mode    = MODE_TEXT;
		p_param   = '0;
		p_qmark   = 1'b0;
		p_ext     = EXT_NONE;
		cur_style = '0;
		wrk_style = '0;
		cur_fg    = COLOUR_DEFAULT;
		cur_bg    = COLOUR_DEFAULT;
		wrk_fg    = COLOUR_DEFAULT;
		wrk_bg    = COLOUR_DEFAULT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_bytes();
		test_sgr_extremes();
		test_sequence_faults();
		test_random_stream();

		s_axis_tvalid <= 1'b0;
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("[ansi_sgr_attribute_parser] OK");
		else
			$display("[ansi_sgr_attribute_parser] ERROR");
		$finish;
	end

endmodule
